// ===== rtl/working_set_page_replacement_core_assert.svh =====
// Assertion macros for the working set page replacement core.
// Included by the top level; expects signals named clk and rst_n in scope.
`ifndef WORKING_SET_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define WORKING_SET_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wspr_pkg.sv =====
// Shared types and constants for the working set page replacement core.
// No dependencies; used by wspr_store and the top level.
package wspr_pkg;

  // Recency stamp width.
  localparam int STAMP_W = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WS_SIZE = 1'b1;

  // Item operation codes.
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_FAULT  = 1'b1;

  // Replacement policy codes.
  localparam logic POL_LRU   = 1'b0;
  localparam logic POL_CLOCK = 1'b1;

  // Slot store update codes.
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_PLACE = 2'd1;
  localparam logic [1:0] ST_TOUCH = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  // Update command from the sequencer to the slot store.
  typedef struct packed {
    logic [1:0] op;
    logic       is_write;
  } st_ctl_t;

endpackage

// ===== rtl/working_set_page_replacement_core.sv =====
// Working set page replacement core. Items are taken one at a time; in_stall is high
// from acceptance until the result has been loaded into the output register, which
// may still be waiting for its transfer when the next item is accepted. With n the
// active slot count (ws_size clamped to 1..WS_MAX), an access scans up to n slots, a
// fault searches from the hand up to n slots for a free one, an LRU eviction scans
// the stamps of all n slots and a clock eviction's second-chance sweep may pass n + 1
// slots; a result may also wait for the previous one to leave the output register.
// The sequencer visits one slot per cycle through the single read port of the page
// and stamp memories and the one shared comparator. Configuration writes go through
// cfg_we, cfg_index and cfg_data and are expected only while the core is idle.
// Depends on wspr_pkg, wspr_store, wspr_cmp and the assertion macro header.
`include "working_set_page_replacement_core_assert.svh"

module working_set_page_replacement_core #(
  parameter int WS_MAX    = 32,
  parameter int PAGE_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port
  input  logic                              cfg_we,
  input  logic [wspr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wspr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [PAGE_BITS-1:0]              in_page_number,
  input  logic                              in_is_write,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [$clog2(WS_MAX)-1:0]         out_slot,
  output logic                              out_evicted,
  output logic [PAGE_BITS-1:0]              out_victim_page,
  output logic                              out_write_back
);

  localparam int SLOT_W = $clog2(WS_MAX);
  localparam int CNT_W  = $clog2(WS_MAX + 1);
  localparam int WSC_W  = (CNT_W > wspr_pkg::CFG_DATA_W) ? CNT_W : wspr_pkg::CFG_DATA_W;
  localparam int CMP_W  = (PAGE_BITS > wspr_pkg::STAMP_W) ? PAGE_BITS : wspr_pkg::STAMP_W;
  localparam logic [WSC_W-1:0] WS_MAX_C = WSC_W'(WS_MAX);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_FREE  = 4'd2;
  localparam logic [3:0] S_LRU   = 4'd3;
  localparam logic [3:0] S_CLK   = 4'd4;
  localparam logic [3:0] S_VRD   = 4'd5;
  localparam logic [3:0] S_VGET  = 4'd6;
  localparam logic [3:0] S_PLACE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]                   state_r, state_nxt;
  logic                         policy_r;
  logic [wspr_pkg::CFG_DATA_W-1:0] ws_size_r;
  logic [SLOT_W-1:0]            hand_r, hand_nxt;
  logic [wspr_pkg::STAMP_W-1:0] tick_r, tick_nxt;
  logic [PAGE_BITS-1:0]         page_r, page_nxt;
  logic                         wr_r, wr_nxt;
  logic [CNT_W-1:0]             n_r, n_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic [SLOT_W-1:0]            cur_r, cur_nxt;
  logic [SLOT_W-1:0]            vic_r, vic_nxt;
  logic [wspr_pkg::STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic [SLOT_W-1:0]            best_idx_r, best_idx_nxt;
  logic                         res_hit_r, res_hit_nxt;
  logic [SLOT_W-1:0]            res_slot_r, res_slot_nxt;
  logic                         res_ev_r, res_ev_nxt;
  logic [PAGE_BITS-1:0]         res_vpage_r, res_vpage_nxt;
  logic                         res_wb_r, res_wb_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]            out_slot_r, out_slot_nxt;
  logic                         out_ev_r, out_ev_nxt;
  logic [PAGE_BITS-1:0]         out_vpage_r, out_vpage_nxt;
  logic                         out_wb_r, out_wb_nxt;

  logic [WSC_W-1:0]             ws_ext;
  logic [CNT_W-1:0]             n_cur;
  logic [SLOT_W-1:0]            hand_start;
  logic [CNT_W-1:0]             cur_inc;
  logic [SLOT_W-1:0]            cur_wrap;
  logic [CNT_W-1:0]             vic_inc;
  logic [SLOT_W-1:0]            vic_wrap;
  logic                         in_xfer;
  logic                         out_xfer;

  wspr_pkg::st_ctl_t            st_ctl;
  logic [SLOT_W-1:0]            st_idx;
  logic [SLOT_W-1:0]            rd_idx;
  logic [PAGE_BITS-1:0]         rd_page;
  logic [wspr_pkg::STAMP_W-1:0] rd_stamp;
  logic [WS_MAX-1:0]            valid_vec;
  logic [WS_MAX-1:0]            used_vec;
  logic [WS_MAX-1:0]            mod_vec;
  logic [CMP_W-1:0]             cmp_a;
  logic [CMP_W-1:0]             cmp_b;
  logic                         cmp_eq;
  logic                         cmp_lt;

  // Slot store and shared comparator.
  wspr_store #(
    .WS_MAX   (WS_MAX),
    .PAGE_BITS(PAGE_BITS),
    .SLOT_W   (SLOT_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (st_ctl),
    .wr_idx   (st_idx),
    .wr_page  (page_r),
    .wr_stamp (tick_r),
    .rd_idx   (rd_idx),
    .rd_page  (rd_page),
    .rd_stamp (rd_stamp),
    .valid_vec(valid_vec),
    .used_vec (used_vec),
    .mod_vec  (mod_vec)
  );

  wspr_cmp #(
    .DW(CMP_W)
  ) u_cmp (
    .a (cmp_a),
    .b (cmp_b),
    .eq(cmp_eq),
    .lt(cmp_lt)
  );

  // Active slot count: zero acts as one, large values clamp to WS_MAX.
  assign ws_ext = WSC_W'(ws_size_r);
  always_comb begin
    if (ws_size_r == '0) begin
      n_cur = CNT_W'(1);
    end else if (ws_ext > WS_MAX_C) begin
      n_cur = CNT_W'(WS_MAX);
    end else begin
      n_cur = CNT_W'(ws_ext);
    end
  end

  // Hand wraps to slot zero if it lies outside the active slots.
  assign hand_start = (CNT_W'(hand_r) >= n_cur) ? '0 : hand_r;

  // Next slot with wrap-around at the active count.
  assign cur_inc  = CNT_W'(cur_r) + CNT_W'(1);
  assign cur_wrap = (cur_inc >= n_r) ? '0 : cur_inc[SLOT_W-1:0];
  assign vic_inc  = CNT_W'(vic_r) + CNT_W'(1);
  assign vic_wrap = (vic_inc >= n_r) ? '0 : vic_inc[SLOT_W-1:0];

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // Comparator operands: page lookup during access, stamps during the LRU scan.
  assign cmp_a = (state_r == S_ACC) ? CMP_W'(page_r) : CMP_W'(rd_stamp);
  assign cmp_b = (state_r == S_ACC) ? CMP_W'(rd_page) : CMP_W'(best_stamp_r);

  // Memory read address.
  assign rd_idx = (state_r == S_VRD) ? vic_r : idx_r[SLOT_W-1:0];

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    hand_nxt       = hand_r;
    tick_nxt       = tick_r;
    page_nxt       = page_r;
    wr_nxt         = wr_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    cur_nxt        = cur_r;
    vic_nxt        = vic_r;
    best_stamp_nxt = best_stamp_r;
    best_idx_nxt   = best_idx_r;
    res_hit_nxt    = res_hit_r;
    res_slot_nxt   = res_slot_r;
    res_ev_nxt     = res_ev_r;
    res_vpage_nxt  = res_vpage_r;
    res_wb_nxt     = res_wb_r;
    st_ctl.op       = wspr_pkg::ST_NONE;
    st_ctl.is_write = wr_r;
    st_idx          = cur_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          page_nxt      = in_page_number;
          wr_nxt        = in_is_write;
          n_nxt         = n_cur;
          idx_nxt       = '0;
          cnt_nxt       = '0;
          cmp_vld_nxt   = 1'b0;
          res_hit_nxt   = 1'b0;
          res_slot_nxt  = '0;
          res_ev_nxt    = 1'b0;
          res_vpage_nxt = '0;
          res_wb_nxt    = 1'b0;
          if (in_operation == wspr_pkg::OP_FAULT) begin
            hand_nxt  = hand_start;
            cur_nxt   = hand_start;
            state_nxt = S_FREE;
          end else begin
            state_nxt = S_ACC;
          end
        end
      end

      // Lookup: one slot issued per cycle, compared in the following cycle.
      S_ACC: begin
        if (cmp_vld_r && valid_vec[cmp_idx_r] && cmp_eq) begin
          st_ctl.op    = wspr_pkg::ST_TOUCH;
          st_idx       = cmp_idx_r;
          tick_nxt     = tick_r + wspr_pkg::STAMP_W'(1);
          res_hit_nxt  = 1'b1;
          res_slot_nxt = cmp_idx_r;
          state_nxt    = S_OUT;
        end else if (idx_r < n_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[SLOT_W-1:0];
          idx_nxt     = idx_r + CNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            state_nxt = S_OUT;
          end
        end
      end

      // Free slot search from the hand.
      S_FREE: begin
        if (!valid_vec[cur_r]) begin
          vic_nxt   = cur_r;
          state_nxt = S_PLACE;
        end else if ((cnt_r + CNT_W'(1)) == n_r) begin
          if (policy_r == wspr_pkg::POL_LRU) begin
            idx_nxt     = '0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_LRU;
          end else begin
            cur_nxt   = hand_r;
            state_nxt = S_CLK;
          end
        end else begin
          cur_nxt = cur_wrap;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      // Oldest stamp search; strict less-than keeps the lowest index on ties.
      S_LRU: begin
        if (cmp_vld_r && ((cmp_idx_r == '0) || cmp_lt)) begin
          best_stamp_nxt = rd_stamp;
          best_idx_nxt   = cmp_idx_r;
        end
        if (idx_r < n_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[SLOT_W-1:0];
          idx_nxt     = idx_r + CNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            vic_nxt   = best_idx_r;
            state_nxt = S_VRD;
          end
        end
      end

      // Second-chance sweep: clear used marks until a clear one is met.
      S_CLK: begin
        if (used_vec[cur_r]) begin
          st_ctl.op = wspr_pkg::ST_CLEAR;
          st_idx    = cur_r;
          cur_nxt   = cur_wrap;
        end else begin
          vic_nxt   = cur_r;
          state_nxt = S_VRD;
        end
      end

      S_VRD: begin
        state_nxt = S_VGET;
      end

      // Victim page arrives from the memory.
      S_VGET: begin
        res_ev_nxt    = 1'b1;
        res_vpage_nxt = rd_page;
        res_wb_nxt    = mod_vec[vic_r];
        state_nxt     = S_PLACE;
      end

      // Fill the chosen slot and move the hand past it.
      S_PLACE: begin
        st_ctl.op    = wspr_pkg::ST_PLACE;
        st_idx       = vic_r;
        tick_nxt     = tick_r + wspr_pkg::STAMP_W'(1);
        hand_nxt     = vic_wrap;
        res_slot_nxt = vic_r;
        state_nxt    = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded once the previous result has gone.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    out_ev_nxt    = out_ev_r;
    out_vpage_nxt = out_vpage_r;
    out_wb_nxt    = out_wb_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_OUT) && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = res_hit_r;
      out_slot_nxt  = res_slot_r;
      out_ev_nxt    = res_ev_r;
      out_vpage_nxt = res_vpage_r;
      out_wb_nxt    = res_wb_r;
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      policy_r    <= wspr_pkg::POL_CLOCK;
      ws_size_r   <= wspr_pkg::CFG_DATA_W'(32);
      hand_r      <= '0;
      tick_r      <= '0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hand_r      <= hand_nxt;
      tick_r      <= tick_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      if (cfg_we) begin
        case (cfg_index)
          wspr_pkg::CFG_POLICY:  policy_r  <= cfg_data[0];
          wspr_pkg::CFG_WS_SIZE: ws_size_r <= cfg_data;
          default:               policy_r  <= policy_r;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    wr_r         <= wr_nxt;
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    cur_r        <= cur_nxt;
    vic_r        <= vic_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_idx_r   <= best_idx_nxt;
    res_hit_r    <= res_hit_nxt;
    res_slot_r   <= res_slot_nxt;
    res_ev_r     <= res_ev_nxt;
    res_vpage_r  <= res_vpage_nxt;
    res_wb_r     <= res_wb_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ev_r     <= out_ev_nxt;
    out_vpage_r  <= out_vpage_nxt;
    out_wb_r     <= out_wb_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_evicted     = out_ev_r;
  assign out_victim_page = out_vpage_r;
  assign out_write_back  = out_wb_r;

  // Checks on the sequencer.
  `WSPR_ASSERT_NEXT(a_busy_after_accept, in_xfer, in_stall, "core not busy after an accepted transfer")
  `WSPR_ASSERT_NOW(a_free_scan_bound, state_r == S_FREE, cnt_r < n_r, "free slot scan overran the active slots")
  `WSPR_ASSERT_NOW(a_victim_valid, state_r == S_VGET, valid_vec[vic_r], "eviction chose an empty slot")
  `WSPR_ASSERT_NEXT(a_tick_step, state_r == S_PLACE, tick_r == $past(tick_r) + wspr_pkg::STAMP_W'(1), "tick did not advance on a fill")

endmodule

// ===== rtl/wspr_store.sv =====
// Slot store: page and stamp memories with one write and one registered read port,
// plus the valid, used and modified flags. Depends on wspr_pkg.
module wspr_store #(
  parameter int WS_MAX    = 32,
  parameter int PAGE_BITS = 20,
  parameter int SLOT_W    = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wspr_pkg::st_ctl_t           ctl,
  input  logic [SLOT_W-1:0]           wr_idx,
  input  logic [PAGE_BITS-1:0]        wr_page,
  input  logic [wspr_pkg::STAMP_W-1:0] wr_stamp,
  input  logic [SLOT_W-1:0]           rd_idx,
  output logic [PAGE_BITS-1:0]        rd_page,
  output logic [wspr_pkg::STAMP_W-1:0] rd_stamp,
  output logic [WS_MAX-1:0]           valid_vec,
  output logic [WS_MAX-1:0]           used_vec,
  output logic [WS_MAX-1:0]           mod_vec
);

  logic [PAGE_BITS-1:0]         page_mem [WS_MAX];
  logic [wspr_pkg::STAMP_W-1:0] stamp_mem [WS_MAX];
  logic [PAGE_BITS-1:0]         rd_page_r;
  logic [wspr_pkg::STAMP_W-1:0] rd_stamp_r;
  logic [WS_MAX-1:0]            valid_r, valid_nxt;
  logic [WS_MAX-1:0]            used_r, used_nxt;
  logic [WS_MAX-1:0]            mod_r, mod_nxt;
  logic                         mem_we;

  assign mem_we = (ctl.op == wspr_pkg::ST_PLACE) || (ctl.op == wspr_pkg::ST_TOUCH);

  // Memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[wr_idx]  <= wr_page;
      stamp_mem[wr_idx] <= wr_stamp;
    end
    rd_page_r  <= page_mem[rd_idx];
    rd_stamp_r <= stamp_mem[rd_idx];
  end

  // Flag updates for the addressed slot.
  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    mod_nxt   = mod_r;
    case (ctl.op)
      wspr_pkg::ST_PLACE: begin
        valid_nxt[wr_idx] = 1'b1;
        used_nxt[wr_idx]  = 1'b1;
        mod_nxt[wr_idx]   = ctl.is_write;
      end
      wspr_pkg::ST_TOUCH: begin
        used_nxt[wr_idx] = 1'b1;
        if (ctl.is_write) begin
          mod_nxt[wr_idx] = 1'b1;
        end
      end
      wspr_pkg::ST_CLEAR: begin
        used_nxt[wr_idx] = 1'b0;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
      mod_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      mod_r   <= mod_nxt;
    end
  end

  assign rd_page   = rd_page_r;
  assign rd_stamp  = rd_stamp_r;
  assign valid_vec = valid_r;
  assign used_vec  = used_r;
  assign mod_vec   = mod_r;

endmodule

// ===== rtl/wspr_cmp.sv =====
// Shared compare unit: equality for page lookup and unsigned less-than for stamps.
// No dependencies.
module wspr_cmp #(
  parameter int DW = 32
) (
  input  logic [DW-1:0] a,
  input  logic [DW-1:0] b,
  output logic          eq,
  output logic          lt
);

  // One comparator pair, operands chosen by the sequencer.
  assign eq = (a == b);
  assign lt = (a < b);

endmodule

// ===== bench/tb_working_set_page_replacement_core.sv =====
// Self-checking testbench for working_set_page_replacement_core: a shadow of the
// working set predicts every result, and a scoreboard checks the result transfers.
// Depends on wspr_pkg and the core itself; needs no files or arguments.

localparam int TB_SLOTS     = 32;
localparam int TB_PAGE_BITS = 20;

typedef struct packed {
  logic                    hit;
  logic [4:0]              slot;
  logic                    evicted;
  logic [TB_PAGE_BITS-1:0] victim_page;
  logic                    write_back;
} page_result_t;

// Shadow copy of the working set together with the queue of predicted results.
class page_set_scoreboard;
  logic                    policy;
  logic [5:0]              ws_size;
  logic                    slot_valid [TB_SLOTS];
  logic [TB_PAGE_BITS-1:0] slot_page  [TB_SLOTS];
  logic                    slot_used  [TB_SLOTS];
  logic                    slot_dirty [TB_SLOTS];
  logic [31:0]             slot_stamp [TB_SLOTS];
  int                      hand;
  logic [31:0]             tick;
  page_result_t            predicted_results[$];
  int                      errors;
  int                      hits;
  int                      evictions;

  function new();
    policy  = wspr_pkg::POL_CLOCK;
    ws_size = 6'd32;
    for (int i = 0; i < TB_SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_page[i]  = '0;
      slot_used[i]  = 1'b0;
      slot_dirty[i] = 1'b0;
      slot_stamp[i] = '0;
    end
    hand      = 0;
    tick      = '0;
    errors    = 0;
    hits      = 0;
    evictions = 0;
  endfunction

  function void write_reg(logic [wspr_pkg::CFG_IDX_W-1:0] index,
                          logic [wspr_pkg::CFG_DATA_W-1:0] data);
    if (index == wspr_pkg::CFG_POLICY) begin
      policy = data[0];
    end else begin
      ws_size = data;
    end
  endfunction

  // Slot count in use, with zero treated as one and large values clamped.
  function int active_slots();
    int n;
    n = ws_size;
    if (n == 0) n = 1;
    if (n > TB_SLOTS) n = TB_SLOTS;
    return n;
  endfunction

  function int pending();
    return predicted_results.size();
  endfunction

  // Returns a page resident in the active slots, or -1 when there is none.
  function int resident_page();
    int picks[$];
    int n;
    n = active_slots();
    for (int i = 0; i < n; i++) begin
      if (slot_valid[i]) picks.push_back(i);
    end
    if (picks.size() == 0) return -1;
    return int'(slot_page[picks[$urandom_range(picks.size() - 1)]]);
  endfunction

  // Applies one accepted item to the shadow and queues the result it should give.
  function void note_item(logic op, logic [TB_PAGE_BITS-1:0] page, logic is_write);
    page_result_t res;
    int           n;
    int           s;
    int           k;
    bit           found;
    res   = '0;
    n     = active_slots();
    found = 1'b0;
    if (op == wspr_pkg::OP_ACCESS) begin
      // Lookup: the lowest matching active slot wins; a miss changes nothing.
      for (int i = 0; i < n; i++) begin
        if (!found && slot_valid[i] && slot_page[i] == page) begin
          found         = 1'b1;
          slot_used[i]  = 1'b1;
          if (is_write) slot_dirty[i] = 1'b1;
          slot_stamp[i] = tick;
          tick          = tick + 1;
          res.hit       = 1'b1;
          res.slot      = i[4:0];
        end
      end
      if (found) hits++;
    end else begin
      // Free slot search from the hand, which wraps if it lies beyond the set.
      if (hand >= n) hand = 0;
      s = hand;
      for (int i = 0; i < n; i++) begin
        k = hand + i;
        if (k >= n) k -= n;
        if (!found && !slot_valid[k]) begin
          s     = k;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (policy == wspr_pkg::POL_LRU) begin
          s = 0;
          for (int i = 1; i < n; i++) begin
            if (slot_stamp[i] < slot_stamp[s]) s = i;
          end
        end else begin
          // Second chance: clear used marks until an unused slot turns up.
          s = hand;
          while (slot_used[s]) begin
            slot_used[s] = 1'b0;
            s++;
            if (s >= n) s = 0;
          end
        end
        res.evicted     = 1'b1;
        res.victim_page = slot_page[s];
        res.write_back  = slot_dirty[s];
        evictions++;
      end
      slot_valid[s] = 1'b1;
      slot_page[s]  = page;
      slot_used[s]  = 1'b1;
      slot_dirty[s] = is_write;
      slot_stamp[s] = tick;
      tick          = tick + 1;
      hand          = s + 1;
      if (hand >= n) hand = 0;
      res.slot      = s[4:0];
    end
    predicted_results.push_back(res);
  endfunction

  function void report_field(string name, logic [TB_PAGE_BITS-1:0] want,
                             logic [TB_PAGE_BITS-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    end
  endfunction

  // Compares one result transfer with the oldest prediction.
  function void check_result(page_result_t got);
    page_result_t want;
    if (predicted_results.size() == 0) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
      end
      return;
    end
    want = predicted_results.pop_front();
    report_field("hit", want.hit, got.hit);
    report_field("slot", want.slot, got.slot);
    report_field("evicted", want.evicted, got.evicted);
    report_field("victim_page", want.victim_page, got.victim_page);
    report_field("write_back", want.write_back, got.write_back);
  endfunction
endclass

module tb_working_set_page_replacement_core;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 40;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [wspr_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [wspr_pkg::CFG_DATA_W-1:0]   cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic                              in_operation;
  logic [TB_PAGE_BITS-1:0]           in_page_number;
  logic                              in_is_write;
  logic                              out_valid;
  logic                              out_stall;
  logic                              out_hit;
  logic [4:0]                        out_slot;
  logic                              out_evicted;
  logic [TB_PAGE_BITS-1:0]           out_victim_page;
  logic                              out_write_back;

  page_set_scoreboard      sb = new();
  logic [TB_PAGE_BITS-1:0] page_pool [POOL_SIZE];
  int                      stall_pct;
  bit                      hold_ask;
  int                      quiet_cycles;
  int                      items_sent;
  int                      settings_run;

  working_set_page_replacement_core #(
    .WS_MAX    (TB_SLOTS),
    .PAGE_BITS (TB_PAGE_BITS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_page_number  (in_page_number),
    .in_is_write     (in_is_write),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_evicted     (out_evicted),
    .out_victim_page (out_victim_page),
    .out_write_back  (out_write_back)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_hit, out_slot, out_evicted, out_victim_page, out_write_back});
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog expired at %0t", $time);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic set_reg(input logic [wspr_pkg::CFG_IDX_W-1:0] index,
                         input logic [wspr_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(index, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one item, waits for its transfer and optionally idles afterwards.
  task automatic send_item(input logic op, input logic [TB_PAGE_BITS-1:0] page,
                           input logic is_write, input int gap_pct);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_page_number <= page;
    in_is_write    <= is_write;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, page, is_write);
    items_sent++;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random phase under a given register setting and idling pattern.
  task automatic run_phase(input logic pol, input logic [5:0] ws, input int count,
                           input int gap_pct, input int recv_pct, input bit hold,
                           input bit mid_pause);
    int          r;
    int          res_page;
    logic        op;
    logic [TB_PAGE_BITS-1:0] page;
    set_reg(wspr_pkg::CFG_WS_SIZE, ws);
    set_reg(wspr_pkg::CFG_POLICY, {5'($urandom_range(31)), pol});
    settings_run++;
    stall_pct = recv_pct;
    if (hold) hold_ask = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (mid_pause && i == count / 2) drain();
      r        = $urandom_range(99);
      res_page = sb.resident_page();
      if (r < 45 && res_page >= 0) begin
        op   = wspr_pkg::OP_ACCESS;
        page = res_page[TB_PAGE_BITS-1:0];
      end else if (r < 80) begin
        op   = wspr_pkg::OP_FAULT;
        page = page_pool[$urandom_range(POOL_SIZE - 1)];
      end else if (r < 90) begin
        op   = wspr_pkg::OP_ACCESS;
        page = TB_PAGE_BITS'($urandom);
      end else if (r < 95) begin
        op   = wspr_pkg::OP_FAULT;
        page = TB_PAGE_BITS'($urandom);
      end else begin
        op   = wspr_pkg::OP_ACCESS;
        page = page_pool[$urandom_range(POOL_SIZE - 1)];
      end
      send_item(op, page, 1'($urandom_range(1)), gap_pct);
    end
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_operation   = wspr_pkg::OP_ACCESS;
    in_page_number = '0;
    in_is_write    = 1'b0;
    stall_pct      = 0;
    hold_ask       = 1'b0;
    items_sent     = 0;
    settings_run   = 1;
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = TB_PAGE_BITS'($urandom);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset setting: fills, hits, writes, a miss, duplicates.
    send_item(wspr_pkg::OP_FAULT, 20'h00000, 1'b1, 0);
    send_item(wspr_pkg::OP_FAULT, 20'hFFFFF, 1'b0, 0);
    send_item(wspr_pkg::OP_ACCESS, 20'h00000, 1'b0, 0);
    send_item(wspr_pkg::OP_ACCESS, 20'hFFFFF, 1'b1, 0);
    send_item(wspr_pkg::OP_ACCESS, 20'h12345, 1'b1, 0);
    send_item(wspr_pkg::OP_FAULT, 20'h00000, 1'b0, 0);
    send_item(wspr_pkg::OP_ACCESS, 20'h00000, 1'b1, 0);
    drain();

    // Shrunken set with the hand beyond it; second-chance evictions.
    set_reg(wspr_pkg::CFG_WS_SIZE, 6'd2);
    send_item(wspr_pkg::OP_FAULT, 20'hAAAAA, 1'b0, 0);
    send_item(wspr_pkg::OP_FAULT, 20'h55555, 1'b1, 0);
    send_item(wspr_pkg::OP_ACCESS, 20'h55555, 1'b0, 0);
    send_item(wspr_pkg::OP_FAULT, 20'h0F0F0, 1'b0, 0);
    drain();

    // Least recently used, with upper bits of the policy data set.
    set_reg(wspr_pkg::CFG_POLICY, 6'b111110);
    send_item(wspr_pkg::OP_FAULT, 20'h33333, 1'b1, 0);
    send_item(wspr_pkg::OP_ACCESS, 20'h33333, 1'b0, 0);
    send_item(wspr_pkg::OP_FAULT, 20'hCCCCC, 1'b0, 0);
    send_item(wspr_pkg::OP_FAULT, 20'hF0F0F, 1'b1, 0);
    drain();

    // A size of zero behaves as a single slot.
    set_reg(wspr_pkg::CFG_WS_SIZE, 6'd0);
    send_item(wspr_pkg::OP_FAULT, 20'h00001, 1'b1, 0);
    send_item(wspr_pkg::OP_FAULT, 20'h00002, 1'b0, 0);
    send_item(wspr_pkg::OP_ACCESS, 20'h00002, 1'b1, 0);
    drain();

    // Oversized set clamps to the full slot count; clock policy again.
    set_reg(wspr_pkg::CFG_WS_SIZE, 6'd63);
    set_reg(wspr_pkg::CFG_POLICY, 6'b000001);
    send_item(wspr_pkg::OP_ACCESS, 20'hFFFFF, 1'b0, 0);
    send_item(wspr_pkg::OP_FAULT, 20'h80000, 1'b1, 0);
    send_item(wspr_pkg::OP_ACCESS, 20'h7FFFF, 1'b0, 0);
    drain();
    settings_run += 4;

    // Random phases: policy, size, items, sender idle %, receiver stall %.
    run_phase(wspr_pkg::POL_CLOCK, 6'd32, 250, 0, 0, 1'b0, 1'b0);
    run_phase(wspr_pkg::POL_LRU, 6'd32, 250, 45, 0, 1'b0, 1'b0);
    run_phase(wspr_pkg::POL_CLOCK, 6'd5, 200, 0, 45, 1'b1, 1'b0);
    run_phase(wspr_pkg::POL_LRU, 6'd1, 150, 17, 17, 1'b0, 1'b0);
    run_phase(wspr_pkg::POL_CLOCK, 6'd0, 100, 45, 0, 1'b0, 1'b0);
    run_phase(wspr_pkg::POL_LRU, 6'd63, 250, 0, 45, 1'b0, 1'b0);
    run_phase(wspr_pkg::POL_CLOCK, 6'd8, 200, 17, 17, 1'b0, 1'b1);
    run_phase(wspr_pkg::POL_LRU, 6'd33, 200, 0, 0, 1'b0, 1'b0);
    run_phase(wspr_pkg::POL_CLOCK, 6'd16, 300, 17, 17, 1'b1, 1'b0);

    stall_pct = 0;
    repeat (80) @(posedge clk);
    $display("Sent %0d items over %0d register settings (both policies, sizes 0 to 63).",
             items_sent, settings_run);
    $display("Observed %0d access hits and %0d evictions.", sb.hits, sb.evictions);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d results never arrived", sb.errors, sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
